// File: hdl/nnsag_pkg.sv
// Shared widths and register index codes for the nearest-neighbor scaler
// address generator. No dependencies; used by the top level and its checker.
package nnsag_pkg;

   // Field widths
   localparam int CFG_DIM_W  = 13;  // width and height registers
   localparam int EB_W       = 3;   // element size register
   localparam int PITCH_W    = 16;  // row pitch registers
   localparam int OFF_W      = 28;  // byte offsets
   localparam int STEP_W     = 16;  // (src_width div dst_width) * bytes

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Stream data widths (whole bytes)
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ELEMENT_BYTES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_ROW_PITCH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DST_ROW_PITCH = 3'd6;

   // Step divider: one quotient bit per cycle
   localparam int DIV_CNT_W  = $clog2(CFG_DIM_W + 1);

endpackage

// File: hdl/nearest_neighbor_scaler_address_gen_unit.sv
// Nearest-neighbor scaler address generator: top level.
// Depends on nnsag_pkg.
//
// Each request beat yields one response beat with the source and destination
// byte offsets of the next destination pixel in raster order; req_tdata[0]
// (restart) first returns the walk to pixel zero zero. The block takes one
// beat per clock while the response stream does not stall and no setup
// runs. A beat goes through the product stage, which forms the row products
// and advances the position accumulators, then the response register, which
// adds the column terms. After any configuration write, req_tready stays low
// through a load step, the bit-per-cycle divider that forms the column and
// row steps, and a step that scales the column step by the element size.
module nearest_neighbor_scaler_address_gen_unit #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [nnsag_pkg::REQ_DATA_W-1:0]    req_tdata,  // [0] restart
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [nnsag_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [27:0] source byte offset,
                                                           // [55:28] dest byte offset
   output logic                                rsp_tuser,  // [0] end_of_row
   output logic                                rsp_tlast,  // end_of_frame
   // configuration writes
   input  logic                                csr_we,
   input  logic [nnsag_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nnsag_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DIM_W = nnsag_pkg::CFG_DIM_W;
   localparam int EB_W  = nnsag_pkg::EB_W;
   localparam int PW    = nnsag_pkg::PITCH_W;
   localparam int OFF_W = nnsag_pkg::OFF_W;
   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int EXT_W = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;

   // setup sequencer codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_SCALE = 2'd3;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   function automatic logic [EB_W-1:0] eff_bytes(input logic [EB_W-1:0] v);
      logic [EB_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = EB_W'(1);
      end else if (v > EB_W'(4)) begin
         r = EB_W'(4);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   logic [DIM_W-1:0] src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [EB_W-1:0]  element_bytes_ff;
   logic [PW-1:0]    src_pitch_ff, dst_pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= DIM_W'(1);
         src_height_ff    <= DIM_W'(1);
         dst_width_ff     <= DIM_W'(1);
         dst_height_ff    <= DIM_W'(1);
         element_bytes_ff <= EB_W'(1);
         src_pitch_ff     <= PW'(1);
         dst_pitch_ff     <= PW'(1);
      end else if (csr_we) begin
         case (csr_index)
            nnsag_pkg::REG_SRC_WIDTH:     src_width_ff     <= csr_wdata[DIM_W-1:0];
            nnsag_pkg::REG_SRC_HEIGHT:    src_height_ff    <= csr_wdata[DIM_W-1:0];
            nnsag_pkg::REG_DST_WIDTH:     dst_width_ff     <= csr_wdata[DIM_W-1:0];
            nnsag_pkg::REG_DST_HEIGHT:    dst_height_ff    <= csr_wdata[DIM_W-1:0];
            nnsag_pkg::REG_ELEMENT_BYTES: element_bytes_ff <= csr_wdata[EB_W-1:0];
            nnsag_pkg::REG_SRC_ROW_PITCH: src_pitch_ff     <= csr_wdata[PW-1:0];
            nnsag_pkg::REG_DST_ROW_PITCH: dst_pitch_ff     <= csr_wdata[PW-1:0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] sw, sh, dw, dh;
   logic [EB_W-1:0]  eb;
   assign sw = eff_dim(src_width_ff);
   assign sh = eff_dim(src_height_ff);
   assign dw = eff_dim(dst_width_ff);
   assign dh = eff_dim(dst_height_ff);
   assign eb = eff_bytes(element_bytes_ff);

   // ------------------------------------------------------------------
   // Step setup: two restoring dividers (lane 0 columns, lane 1 rows)
   logic [1:0]                      st_ff, st_in;
   logic [nnsag_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIM_W-1:0]                quo_ff [2];
   logic [DIM_W-1:0]                rem_ff [2];
   logic [DIM_W-1:0]                dvs_ff [2];
   logic [DIM_W-1:0]                quo_in [2];
   logic [DIM_W-1:0]                rem_in [2];
   logic [DIM_W-1:0]                dvs_in [2];
   logic [DIM_W:0]                  trial  [2];

   logic [nnsag_pkg::STEP_W-1:0]    col_step_ff, col_step_in;
   logic [CNT_W-1:0]                col_rem_ff, col_rem_in;
   logic [DIM_W-1:0]                row_step_ff, row_step_in;
   logic [CNT_W-1:0]                row_rem_ff, row_rem_in;

   always_comb begin
      st_in       = st_ff;
      cnt_in      = cnt_ff;
      col_step_in = col_step_ff;
      col_rem_in  = col_rem_ff;
      row_step_in = row_step_ff;
      row_rem_in  = row_rem_ff;
      for (int i = 0; i < 2; i++) begin
         quo_in[i] = quo_ff[i];
         rem_in[i] = rem_ff[i];
         dvs_in[i] = dvs_ff[i];
         trial[i]  = {rem_ff[i], quo_ff[i][DIM_W-1]};
      end
      case (st_ff)
         ST_LOAD: begin
            quo_in[0] = sw;
            dvs_in[0] = dw;
            quo_in[1] = sh;
            dvs_in[1] = dh;
            rem_in[0] = '0;
            rem_in[1] = '0;
            cnt_in    = '0;
            st_in     = ST_DIV;
         end
         ST_DIV: begin
            for (int i = 0; i < 2; i++) begin
               if (trial[i] >= {1'b0, dvs_ff[i]}) begin
                  rem_in[i] = DIM_W'(trial[i] - {1'b0, dvs_ff[i]});
                  quo_in[i] = {quo_ff[i][DIM_W-2:0], 1'b1};
               end else begin
                  rem_in[i] = trial[i][DIM_W-1:0];
                  quo_in[i] = {quo_ff[i][DIM_W-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == nnsag_pkg::DIV_CNT_W'(DIM_W - 1)) begin
               st_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            col_step_in = nnsag_pkg::STEP_W'(quo_ff[0] * nnsag_pkg::STEP_W'(eb));
            col_rem_in  = CNT_W'(rem_ff[0]);
            row_step_in = quo_ff[1];
            row_rem_in  = CNT_W'(rem_ff[1]);
            st_in       = ST_IDLE;
         end
         default: ;
      endcase
      // any write restarts the setup
      if (csr_we) begin
         st_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         cnt_ff      <= '0;
         col_step_ff <= nnsag_pkg::STEP_W'(1);
         col_rem_ff  <= '0;
         row_step_ff <= DIM_W'(1);
         row_rem_ff  <= '0;
      end else begin
         st_ff       <= st_in;
         cnt_ff      <= cnt_in;
         col_step_ff <= col_step_in;
         col_rem_ff  <= col_rem_in;
         row_step_ff <= row_step_in;
         row_rem_ff  <= row_rem_in;
      end
   end

   // divider datapath
   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         quo_ff[i] <= quo_in[i];
         rem_ff[i] <= rem_in[i];
         dvs_ff[i] <= dvs_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Handshake and stage control
   logic p_vld_ff, o_vld_ff;
   logic p_adv, o_adv, accept;

   assign o_adv      = !o_vld_ff || rsp_tready;
   assign p_adv      = !p_vld_ff || o_adv;
   assign req_tready = p_adv && (st_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         if (p_adv) begin
            p_vld_ff <= accept;
         end
         if (o_adv) begin
            o_vld_ff <= p_vld_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Position state
   logic [CNT_W-1:0] dcol_ff, drow_ff, crem_ff, rrem_ff;
   logic [OFF_W-1:0] scb_ff, srow_ff;
   logic [CNT_W-1:0] dcol_in, drow_in, crem_in, rrem_in;
   logic [OFF_W-1:0] scb_in, srow_in;

   // current position, restart applied
   logic [CNT_W-1:0] dcol_c, drow_c, crem_c, rrem_c;
   logic [OFF_W-1:0] scb_c, srow_c;
   logic             restart, last_col, last_row;
   logic [EXT_W-1:0] csum, rsum;

   assign restart = req_tdata[0];

   always_comb begin
      if (restart) begin
         dcol_c = '0;
         drow_c = '0;
         crem_c = '0;
         rrem_c = '0;
         scb_c  = '0;
         srow_c = '0;
      end else begin
         dcol_c = dcol_ff;
         drow_c = drow_ff;
         crem_c = crem_ff;
         rrem_c = rrem_ff;
         scb_c  = scb_ff;
         srow_c = srow_ff;
      end

      last_col = (EXT_W'(dcol_c) + EXT_W'(1)) >= EXT_W'(dw);
      last_row = (EXT_W'(drow_c) + EXT_W'(1)) >= EXT_W'(dh);
      csum     = EXT_W'(crem_c) + EXT_W'(col_rem_ff);
      rsum     = EXT_W'(rrem_c) + EXT_W'(row_rem_ff);

      dcol_in = '0;
      drow_in = '0;
      crem_in = '0;
      rrem_in = '0;
      scb_in  = '0;
      srow_in = '0;
      if (!last_col) begin
         // next pixel in the row
         dcol_in = dcol_c + 1'b1;
         drow_in = drow_c;
         rrem_in = rrem_c;
         srow_in = srow_c;
         if (csum >= EXT_W'(dw)) begin
            crem_in = CNT_W'(csum - EXT_W'(dw));
            scb_in  = scb_c + OFF_W'(col_step_ff) + OFF_W'(eb);
         end else begin
            crem_in = CNT_W'(csum);
            scb_in  = scb_c + OFF_W'(col_step_ff);
         end
      end else if (!last_row) begin
         // first pixel of the next row
         drow_in = drow_c + 1'b1;
         if (rsum >= EXT_W'(dh)) begin
            rrem_in = CNT_W'(rsum - EXT_W'(dh));
            srow_in = srow_c + OFF_W'(row_step_ff) + OFF_W'(1);
         end else begin
            rrem_in = CNT_W'(rsum);
            srow_in = srow_c + OFF_W'(row_step_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcol_ff <= '0;
         drow_ff <= '0;
         crem_ff <= '0;
         rrem_ff <= '0;
         scb_ff  <= '0;
         srow_ff <= '0;
      end else if (accept) begin
         dcol_ff <= dcol_in;
         drow_ff <= drow_in;
         crem_ff <= crem_in;
         rrem_ff <= rrem_in;
         scb_ff  <= scb_in;
         srow_ff <= srow_in;
      end
   end

   // ------------------------------------------------------------------
   // Product stage: row terms and column byte offsets
   logic [OFF_W-1:0] p_sprod_ff, p_dprod_ff, p_scb_ff, p_dcb_ff;
   logic             p_eor_ff, p_eof_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         p_sprod_ff <= srow_c * OFF_W'(src_pitch_ff);
         p_dprod_ff <= OFF_W'(drow_c) * OFF_W'(dst_pitch_ff);
         p_scb_ff   <= scb_c;
         p_dcb_ff   <= OFF_W'(dcol_c) * OFF_W'(eb);
         p_eor_ff   <= last_col;
         p_eof_ff   <= last_col && last_row;
      end
   end

   // ------------------------------------------------------------------
   // Response register
   logic [OFF_W-1:0] o_src_ff, o_dst_ff;
   logic             o_eor_ff, o_eof_ff;

   always_ff @(posedge clock) begin
      if (o_adv && p_vld_ff) begin
         o_src_ff <= p_sprod_ff + p_scb_ff;
         o_dst_ff <= p_dprod_ff + p_dcb_ff;
         o_eor_ff <= p_eor_ff;
         o_eof_ff <= p_eof_ff;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {o_dst_ff, o_src_ff};
   assign rsp_tuser  = o_eor_ff;
   assign rsp_tlast  = o_eof_ff;

endmodule

// File: hdl/nnsag_checker.sv
// Port-level checks for the nearest-neighbor scaler address generator.
// Depends on nnsag_pkg; bound to nearest_neighbor_scaler_address_gen_unit.
module nnsag_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [nnsag_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast,
   input logic                             csr_we
);

   // nothing comes out of reset pending
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // the last pixel of a frame is always the last pixel of a row
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("end of frame without end of row");

   // a register write holds off requests while the steps are rebuilt
   a_cfg_hold: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("request taken right after a configuration write");

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tlast)))
      else $error("stalled response beat changed");

endmodule

bind nearest_neighbor_scaler_address_gen_unit nnsag_checker u_nnsag_checker (.*);
